### design/i2p_pkg.sv
// Package with the character codes, result kinds and operator precedence for the converter.
package i2p_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] rank_t;

    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_CARET  = 8'h5E;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_LOW_A  = 8'h61;
    localparam char_t CH_LOW_Z  = 8'h7A;
    localparam char_t CH_UP_A   = 8'h41;
    localparam char_t CH_UP_Z   = 8'h5A;
    localparam char_t CH_NUL    = 8'h00;

    localparam kind_t KIND_SYMBOL   = 2'd0;
    localparam kind_t KIND_END      = 2'd1;
    localparam kind_t KIND_OVERFLOW = 2'd2;

    // Characters without a precedence take rank zero, below every operator.
    function automatic rank_t rank_of(input char_t ch);
        rank_t r;
        case (ch)
            CH_PLUS, CH_MINUS: r = 2'd1;
            CH_STAR, CH_SLASH: r = 2'd2;
            CH_CARET:          r = 2'd3;
            default:           r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_letter(input char_t ch);
        return (ch inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]});
    endfunction

endpackage

### design/infix_to_postfix_converter.sv
// Shunting-yard converter: infix characters in, postfix characters out.
//
// Input channel s_*: one transfer carries one infix character in s_tdata, or an
// end-of-expression marker when s_tuser is high. Output channel m_*: each transfer
// carries one postfix character or a terminator/overflow code in m_tuser, and
// m_tlast marks the final result caused by an input transfer.
// The block works on one input at a time. s_tready is high only while it waits
// for an input; the input is registered first, and each result is then registered
// in the output register. A letter or a '(' takes one step. An operator or ')' takes
// one step plus one per stack entry it emits; an end marker emits every stacked entry
// and then a terminator. The stack memory has a single read port, and its registered
// output always holds the entry below the top.
// The output register lets the next input be taken while a result still waits.
// When m_tready is low with a result held, the sequencer stops until it is taken.
// Reset empties the stack at once; the stack memory itself is not cleared, since
// only entries that have been pushed are ever read.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    i2p_pkg::char_t       top_reg, top_next;
    logic                 op_reg;
    i2p_pkg::char_t       ch_reg;

    i2p_pkg::char_t       stack_mem [STACK_DEPTH];
    i2p_pkg::char_t       second_reg;
    logic [AW-1:0]        rd_addr;

    logic                 out_free;
    logic                 emit;
    i2p_pkg::char_t       e_char;
    i2p_pkg::kind_t       e_kind;
    logic                 e_last;
    logic                 push;
    logic                 has_top, has_second, full;
    i2p_pkg::rank_t       ch_rank;

    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_tvalid || m_tready;
    assign has_top    = (cnt_reg != '0);
    assign has_second = (cnt_reg >= CNT_W'(2));
    assign full       = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign ch_rank    = i2p_pkg::rank_of(ch_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        emit       = 1'b0;
        e_char     = i2p_pkg::CH_NUL;
        e_kind     = i2p_pkg::KIND_SYMBOL;
        e_last     = 1'b0;
        push       = 1'b0;
        if (state_reg == ST_IDLE)
        begin
            if (s_tvalid)
            begin
                state_next = ST_RUN;
            end
        end
        else if (out_free)
        begin
            if (op_reg)
            begin
                if (has_top)
                begin
                    emit     = 1'b1;
                    e_char   = top_reg;
                    cnt_next = cnt_reg - CNT_W'(1);
                    top_next = second_reg;
                end
                else
                begin
                    emit       = 1'b1;
                    e_kind     = i2p_pkg::KIND_END;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            else if (i2p_pkg::is_letter(ch_reg))
            begin
                emit       = 1'b1;
                e_char     = ch_reg;
                e_last     = 1'b1;
                state_next = ST_IDLE;
            end
            else if (ch_reg == i2p_pkg::CH_RPAREN)
            begin
                if (!has_top)
                begin
                    state_next = ST_IDLE;
                end
                else if (top_reg == i2p_pkg::CH_LPAREN)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    top_next   = second_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit     = 1'b1;
                    e_char   = top_reg;
                    e_last   = !has_second || (second_reg == i2p_pkg::CH_LPAREN);
                    cnt_next = cnt_reg - CNT_W'(1);
                    top_next = second_reg;
                end
            end
            else if (ch_reg != i2p_pkg::CH_LPAREN && has_top &&
                     ch_rank <= i2p_pkg::rank_of(top_reg))
            begin
                // Popping frees a slot, so the push that follows cannot overflow.
                emit     = 1'b1;
                e_char   = top_reg;
                e_last   = !(has_second && ch_rank <= i2p_pkg::rank_of(second_reg));
                cnt_next = cnt_reg - CNT_W'(1);
                top_next = second_reg;
            end
            else if (full)
            begin
                emit       = 1'b1;
                e_kind     = i2p_pkg::KIND_OVERFLOW;
                e_last     = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                push       = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                top_next   = ch_reg;
                state_next = ST_IDLE;
            end
        end
    end

    // The memory is always read at the slot below the coming top of stack.
    assign rd_addr = (cnt_next >= CNT_W'(2)) ? AW'(cnt_next - CNT_W'(2)) : '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[AW'(cnt_reg)] <= ch_reg;
        end
        second_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tuser;
            ch_reg <= s_tdata;
        end
        if (emit)
        begin
            m_tdata <= e_char;
            m_tuser <= e_kind;
            m_tlast <= e_last;
        end
    end

endmodule

### design/i2p_checker.sv
// Port-level checker for the converter and the bind that attaches it.
module i2p_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A held result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output payload changed");

    // One input is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while the previous one is still in work");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == i2p_pkg::KIND_SYMBOL || m_tuser == i2p_pkg::KIND_END ||
                     m_tuser == i2p_pkg::KIND_OVERFLOW)
        else $error("illegal result kind");

    // Terminators and overflow reports carry no character and close the input.
    a_code_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != i2p_pkg::KIND_SYMBOL |-> m_tdata == i2p_pkg::CH_NUL && m_tlast)
        else $error("terminator or overflow result malformed");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
